### rtl/discrete_histogram_selectivity_macros.svh
// Assertion macros shared by the histogram selectivity RTL.
`ifndef DISCRETE_HISTOGRAM_SELECTIVITY_MACROS_SVH
`define DISCRETE_HISTOGRAM_SELECTIVITY_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DHS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define DHS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define DHS_ASSERT(label, clk, rst_n, prop, msg)
`define DHS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

### rtl/dhs_pkg.sv
// Shared types and codes of the histogram selectivity block.
package dhs_pkg;
	localparam logic [2:0] MODE_LEARN  = 3'd0;
	localparam logic [2:0] MODE_NULL   = 3'd1;
	localparam logic [2:0] MODE_INSERT = 3'd2;
	localparam logic [2:0] MODE_DELETE = 3'd3;
	localparam logic [2:0] MODE_QUERY  = 3'd4;

	localparam logic [2:0] OP_EQ   = 3'd0;
	localparam logic [2:0] OP_LT   = 3'd1;
	localparam logic [2:0] OP_LE   = 3'd2;
	localparam logic [2:0] OP_GT   = 3'd3;
	localparam logic [2:0] OP_GE   = 3'd4;
	localparam logic [2:0] OP_NULL = 3'd5;
	localparam logic [2:0] OP_MEAN = 3'd6;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_ABSENT = 2'd2;

	localparam int unsigned ONE_Q16 = 65536;

	typedef struct packed {
		logic        start;
		logic [95:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [95:0] quotient;
		logic [31:0] remainder;
	} div_rsp_t;
endpackage

### rtl/dhs_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`include "discrete_histogram_selectivity_macros.svh"
module dhs_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  dhs_pkg::div_req_t req,
	output dhs_pkg::div_rsp_t rsp
);
	import dhs_pkg::*;
	logic [95:0] quo_q;
	logic [31:0] den_q;
	logic [32:0] rem_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] shifted;
	logic [33:0] diff;

	assign shifted = {rem_q[31:0], quo_q[95]};
	assign diff = {1'b0, shifted} - {2'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd96;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!diff[33]) begin
				rem_q <= diff[32:0];
				quo_q <= {quo_q[94:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[94:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;
	assign rsp.remainder = rem_q[31:0];

	`DHS_ASSERT_NEXT(a_done_pulse, clk, arst_n, done_q, !done_q, "divider done held")
	`DHS_ASSERT(a_no_restart, clk, arst_n, !(req.start && busy_q), "divider restarted busy")
	`DHS_ASSERT(a_done_idle, clk, arst_n, !(done_q && busy_q), "done while busy")
endmodule

### rtl/dhs_bin_ram.sv
// Bin store: sorted values and counts in one synchronous memory.
module dhs_bin_ram #(
	parameter int ADDR_BITS = 8,
	parameter int WORD_BITS = 64
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [WORD_BITS-1:0] wdata,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [WORD_BITS-1:0] rdata
);
	logic [WORD_BITS-1:0] mem [2**ADDR_BITS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/discrete_histogram_selectivity.sv
// Top level of the frequency histogram selectivity estimator.
//  channel  dir  tdata / tuser contents
//  s_axis   in   tdata {value[31:0], query_op[2:0], mode[2:0]} 40 bits
//  m_axis   out  tdata {status, distinct_bins, expectation, probability} 80 bits
// One word is handled at a time: a scan of the used bins, then for an insert or a
// delete a shift of the bins that move, then the divisions.
// Accepted updates and plain queries need one division; the mean query one per bin plus one.
// Reset clears the counters only; the bin memory needs no clearing pass.
// A finished result waits in the output register while the next word may be taken.
`include "discrete_histogram_selectivity_macros.svh"
module discrete_histogram_selectivity #(
	parameter int MAX_BINS = 256,
	parameter int VALUE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // mode[2:0], query_op[5:3], value[37:6], pad
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata   // probability, expectation, distinct_bins, status, pad
);
	import dhs_pkg::*;
	localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int CW = AW + 1;
	localparam logic [CW-1:0] MAXB = CW'(MAX_BINS);

	localparam logic [3:0] S_IDLE = 4'd0, S_SCAN = 4'd1, S_SHUP = 4'd2, S_SHDN = 4'd3,
		S_DONE = 4'd4, S_DIV = 4'd5, S_MEAN = 4'd6, S_OUT = 4'd7, S_FRAC = 4'd8,
		S_WAIT = 4'd9;

	logic [3:0] st_q;
	logic [2:0] mode_q, op_q;
	logic signed [VALUE_BITS-1:0] val_q;
	logic [CW-1:0] used_q, idx_q, pos_q;
	logic [31:0] rows_q, nulls_q;
	logic [16:0] nfrac_q;
	logic [33:0] lt_q, le_q, all_q;
	logic found_q, pos_set_q;
	logic [63:0] hit_q;
	logic [1:0] status_q;
	logic [16:0] prob_q;
	logic [47:0] expect_q;
	logic signed [49:0] whole_q;
	logic [32:0] rem_q;
	logic neg_q;
	logic [1:0] div_kind_q;
	logic obuf_v_q;
	logic [79:0] obuf_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [63:0] wdata, rdata;
	div_req_t dreq;
	div_rsp_t drsp;

	logic signed [VALUE_BITS-1:0] rv, in_v;
	logic [31:0] rc;
	assign rv = rdata[VALUE_BITS-1:0];
	assign rc = rdata[63:32];
	assign in_v = s_axis_tdata[6 +: VALUE_BITS];

	dhs_bin_ram #(.ADDR_BITS(AW), .WORD_BITS(64)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);
	dhs_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign s_axis_tready = (st_q == S_IDLE);
	assign m_axis_tvalid = obuf_v_q;
	assign m_axis_tdata = obuf_q;

	// Scan reads the entry at idx_q; its data arrives as rdata in the next cycle.
	logic rd_v_q;
	logic [CW-1:0] rd_i_q;
	logic [31:0] mag;
	logic [63:0] prod_s1;
	logic prod_v_s1, prod_neg_s1;
	assign mag = rv[VALUE_BITS-1] ? 32'(-{{(33-VALUE_BITS){rv[VALUE_BITS-1]}}, rv})
		: 32'(rv);

	always_comb begin
		raddr = (st_q == S_SHUP) ? AW'(idx_q - 1'b1) : idx_q[AW-1:0];
		we = 1'b0;
		waddr = idx_q[AW-1:0];
		wdata = rdata;
		if (st_q == S_SHUP && rd_v_q) begin
			we = 1'b1;
			waddr = AW'(rd_i_q + 1'b1);
		end else if (st_q == S_SHDN && rd_v_q) begin
			we = 1'b1;
			waddr = AW'(rd_i_q - 1'b1);
		end else if (st_q == S_DONE && hit_q[0]) begin
			we = 1'b1;
			waddr = pos_q[AW-1:0];
			wdata = {hit_q[63:32], 32'(unsigned'(val_q))};
		end
	end

	logic [95:0] fr_num;
	always_comb begin
		dreq = '0;
		fr_num = '0;
		unique case (op_q)
			OP_EQ: fr_num = 96'(le_q - lt_q);
			OP_LT: fr_num = 96'(lt_q);
			OP_LE: fr_num = 96'(le_q);
			OP_GT: fr_num = 96'(all_q - le_q);
			OP_GE: fr_num = 96'(all_q - lt_q);
			default: fr_num = 96'(nulls_q);
		endcase
		if (st_q == S_DIV && div_kind_q == 2'd0) begin
			dreq.start = 1'b1;
			dreq.divisor = rows_q;
			dreq.dividend = (mode_q == MODE_QUERY ? (fr_num << 16) : (96'(nulls_q) << 16))
				+ 96'(rows_q >> 1);
		end else if (st_q == S_MEAN && prod_v_s1) begin
			dreq.start = 1'b1;
			dreq.divisor = rows_q;
			dreq.dividend = 96'(prod_s1);
		end else if (st_q == S_FRAC) begin
			dreq.start = 1'b1;
			dreq.divisor = rows_q;
			dreq.dividend = (96'(rem_q[31:0]) << 16) + 96'(rows_q >> 1);
		end
	end

	logic [16:0] q_sat;
	assign q_sat = (drsp.quotient > 96'(ONE_Q16)) ? 17'(ONE_Q16) : drsp.quotient[16:0];

	logic [32:0] rem_add;
	logic signed [49:0] whole_add;
	always_comb begin
		whole_add = whole_q;
		rem_add = rem_q;
		if (!neg_q) begin
			whole_add = whole_q + 50'(drsp.quotient[63:0]);
			rem_add = rem_q + 33'(drsp.remainder);
		end else begin
			whole_add = whole_q - 50'(drsp.quotient[63:0]);
			if (drsp.remainder != 0) begin
				whole_add = whole_add - 50'sd1;
				rem_add = rem_q + 33'(rows_q - drsp.remainder);
			end
		end
		if (rem_add >= 33'(rows_q)) begin
			rem_add = rem_add - 33'(rows_q);
			whole_add = whole_add + 50'sd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			used_q <= '0;
			rows_q <= '0;
			nulls_q <= '0;
			nfrac_q <= '0;
			obuf_v_q <= 1'b0;
			rd_v_q <= 1'b0;
			prod_v_s1 <= 1'b0;
			div_kind_q <= '0;
		end else begin
			if (m_axis_tready) obuf_v_q <= 1'b0;
			rd_v_q <= 1'b0;
			prod_v_s1 <= 1'b0;
			unique case (st_q)
				S_IDLE: if (s_axis_tvalid) begin
					mode_q <= s_axis_tdata[2:0];
					op_q <= s_axis_tdata[5:3];
					val_q <= in_v;
					idx_q <= '0;
					lt_q <= '0; le_q <= '0; all_q <= '0;
					found_q <= 1'b0; pos_set_q <= 1'b0;
					pos_q <= used_q;
					status_q <= ST_OK; prob_q <= '0; expect_q <= '0;
					whole_q <= '0; rem_q <= '0;
					div_kind_q <= '0;
					st_q <= S_SCAN;
				end
				S_SCAN: begin
					if (rd_v_q) begin
						all_q <= all_q + 34'(rc);
						if (rv < val_q) lt_q <= lt_q + 34'(rc);
						if (rv <= val_q) le_q <= le_q + 34'(rc);
						if (!pos_set_q && !(rv < val_q)) begin
							pos_set_q <= 1'b1;
							pos_q <= rd_i_q;
							found_q <= (rv == val_q);
							hit_q <= rdata;
						end
					end
					if (idx_q < used_q) begin
						rd_v_q <= 1'b1;
						rd_i_q <= idx_q;
						idx_q <= idx_q + 1'b1;
					end else if (!rd_v_q) begin
						st_q <= S_DONE;
						hit_q[0] <= 1'b0;
						if ((mode_q == MODE_LEARN || mode_q == MODE_INSERT)) begin
							if (rows_q == '1) begin
								status_q <= ST_FULL; st_q <= S_OUT;
							end else if (found_q) begin
								hit_q <= {hit_q[63:32] + 32'd1, hit_q[31:1], 1'b1};
								rows_q <= rows_q + 32'd1;
								div_kind_q <= 2'd0;
							end else if (used_q >= MAXB) begin
								status_q <= ST_FULL; st_q <= S_OUT;
							end else begin
								idx_q <= used_q;
								st_q <= S_SHUP;
							end
						end else if (mode_q == MODE_NULL) begin
							if (rows_q == '1) begin
								status_q <= ST_FULL;
								st_q <= S_OUT;
							end else begin
								rows_q <= rows_q + 32'd1;
								nulls_q <= nulls_q + 32'd1;
								st_q <= S_DIV;
							end
						end else if (mode_q == MODE_DELETE) begin
							if (!found_q || hit_q[63:32] == '0) begin
								status_q <= ST_ABSENT; st_q <= S_OUT;
							end else begin
								if (rows_q != '0) rows_q <= rows_q - 32'd1;
								if (hit_q[63:32] == 32'd1) begin
									idx_q <= pos_q + 1'b1;
									st_q <= S_SHDN;
								end else begin
									hit_q <= {hit_q[63:32] - 32'd1, hit_q[31:1], 1'b1};
								end
							end
						end else if (mode_q == MODE_QUERY) begin
							if (op_q == OP_NULL) begin
								prob_q <= nfrac_q; expect_q <= 48'(nfrac_q); st_q <= S_OUT;
							end else if (used_q == '0 || rows_q == '0 || op_q == 3'd7) begin
								st_q <= S_OUT;
							end else if (op_q == OP_MEAN) begin
								idx_q <= '0; st_q <= S_MEAN;
							end else begin
								st_q <= S_DIV;
							end
						end else begin
							st_q <= S_OUT;
						end
					end
				end
				S_SHUP: begin
					// Move entries up from the top, one a cycle, down to pos.
					if (idx_q > pos_q) begin
						rd_v_q <= 1'b1; rd_i_q <= idx_q - 1'b1; idx_q <= idx_q - 1'b1;
					end else if (!rd_v_q) begin
						hit_q <= {32'd1, 31'(unsigned'(val_q) >> 1), 1'b1};
						used_q <= used_q + 1'b1;
						rows_q <= rows_q + 32'd1;
						st_q <= S_DONE;
					end
				end
				S_SHDN: begin
					if (idx_q < used_q) begin
						rd_v_q <= 1'b1; rd_i_q <= idx_q; idx_q <= idx_q + 1'b1;
					end else if (!rd_v_q) begin
						used_q <= used_q - 1'b1;
						hit_q[0] <= 1'b0;
						st_q <= S_DONE;
					end
				end
				S_DONE: begin
					// Write back the touched entry when one is kept, then refresh the null fraction.
					st_q <= S_DIV;
					div_kind_q <= 2'd0;
				end
				S_DIV: begin
					if (div_kind_q == 2'd0) begin
						div_kind_q <= 2'd1;
					end else if (drsp.done) begin
						div_kind_q <= 2'd0;
						if (mode_q == MODE_QUERY) begin
							prob_q <= q_sat; expect_q <= 48'(q_sat);
						end else begin
							nfrac_q <= (rows_q == '0) ? '0 : q_sat;
						end
						st_q <= S_OUT;
					end
				end
				S_MEAN: begin
					if (div_kind_q == 2'd0) begin
						if (rd_v_q) begin
							prod_s1 <= 64'(rc) * 64'(mag);
							prod_neg_s1 <= rv[VALUE_BITS-1];
							prod_v_s1 <= 1'b1;
						end else if (prod_v_s1) begin
							neg_q <= prod_neg_s1;
							div_kind_q <= 2'd1;
						end else if (idx_q < used_q) begin
							rd_v_q <= 1'b1; rd_i_q <= idx_q; idx_q <= idx_q + 1'b1;
						end else begin
							st_q <= S_FRAC;
						end
					end else if (drsp.done) begin
						whole_q <= whole_add; rem_q <= rem_add;
						div_kind_q <= 2'd0;
					end
				end
				S_FRAC: st_q <= S_WAIT;
				S_WAIT: if (drsp.done) begin
					prob_q <= 17'(ONE_Q16);
					expect_q <= 48'((whole_q <<< 16) + 50'(drsp.quotient[16:0]));
					st_q <= S_OUT;
				end
				S_OUT: if (!obuf_v_q || m_axis_tready) begin
					obuf_v_q <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_OUT && (!obuf_v_q || m_axis_tready)) begin
			obuf_q <= {4'd0, status_q, 9'(used_q), expect_q, prob_q};
		end
	end

	`DHS_ASSERT(a_used_max, clk, arst_n, used_q <= MAXB, "bin count above capacity")
	`DHS_ASSERT(a_ready_idle, clk, arst_n, !(s_axis_tready && st_q != S_IDLE), "ready busy")
	`DHS_ASSERT(a_nulls_rows, clk, arst_n, nulls_q <= rows_q, "more nulls than rows")
endmodule
